>>> rtl/ffha_pkg.sv
package ffha_pkg;
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NULL       = 3'd1;
  localparam logic [2:0] ST_HEAP_FULL  = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_UNKNOWN    = 3'd4;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef struct packed {
    logic        nul;
    logic        kind;
    logic [23:0] size;
    logic [23:0] addr;
  } req_t;
endpackage

>>> rtl/first_fit_heap_allocator.sv
// First-fit heap allocator. Null requests are answered from the queue head;
// others scan the table entry by entry (up to MAX_BLOCKS entries); a scan
// ending without a match finishes in an end step. Requests may wait in the queue.
// Throughput: one request at a time in the table engine; a 2-entry queue
// buffers requests. The one-read-port table is scanned one entry at a time.
// Reset (synchronous, rst_n low): table empty, break = heap_base = 0,
// heap_limit = 2^24. The receiver cannot stall: results are strobed.
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [23:0] in_request_size,
  input  logic [23:0] in_block_address,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [24:0] cfg_wdata,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [23:0] out_payload_address,
  output logic        out_reused_block,
  output logic        out_top_released
);
  logic [24:0] heap_limit_r;
  logic        q_valid, q_pop, done;
  ffha_pkg::req_t q_req;
  logic [2:0]  st;
  logic [23:0] pay;
  logic        reused, top, base_wr;

  // heap_base only matters through the break, which the engine holds
  assign base_wr = cfg_we && cfg_index == ffha_pkg::CFG_BASE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r <= 25'h1000000;
    end else if (cfg_we && cfg_index == ffha_pkg::CFG_LIMIT) begin
      heap_limit_r <= cfg_wdata;
    end
  end

  ffha_front u_front (
    .clk, .rst_n, .start, .busy,
    .req_type(in_req_type), .request_size(in_request_size),
    .block_address(in_block_address),
    .q_valid, .q_req, .q_pop
  );

  // break follows a base write only while the table is empty
  ffha_back #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_back (
    .clk, .rst_n, .q_valid, .q_req, .q_pop,
    .heap_base(cfg_wdata[23:0]), .heap_limit(heap_limit_r), .base_wr,
    .done, .st, .pay, .reused, .top
  );

  // every request, null ones too, goes through the queue, so results keep order
  assign out_valid = done;
  assign out_status = st;
  assign out_payload_address = pay;
  assign out_reused_block = reused;
  assign out_top_released = top;
endmodule

>>> rtl/ffha_front.sv
// Request front: takes commands, tags null requests, queues all of them in order.
module ffha_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic            req_type,
  input  logic [23:0]     request_size,
  input  logic [23:0]     block_address,
  output logic            q_valid,
  output ffha_pkg::req_t  q_req,
  input  logic            q_pop
);
  // two-entry queue
  ffha_pkg::req_t q_mem_r [2];
  logic           rd_ptr_r, wr_ptr_r;
  logic [1:0]     cnt_r;
  logic           acc, is_null, push;

  assign busy = (cnt_r == 2'd2);
  assign acc = start && !busy;
  assign is_null = (req_type == ffha_pkg::REQ_ALLOC) ? (request_size == 24'd0)
                                                    : (block_address == 24'd0);
  assign push = acc;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{nul: is_null, kind: req_type, size: request_size,
                             addr: block_address};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

>>> rtl/ffha_back.sv
// Table engine: scans the block table one entry at a time, one request at a time.
module ffha_back #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  ffha_pkg::req_t  q_req,
  output logic            q_pop,
  input  logic [23:0]     heap_base,
  input  logic [24:0]     heap_limit,
  input  logic            base_wr,
  output logic            done,
  output logic [2:0]      st,
  output logic [23:0]     pay,
  output logic            reused,
  output logic            top
);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [1:0] S_IDLE = 2'd0, S_RD = 2'd1, S_CHK = 2'd2, S_END = 2'd3;

  logic [23:0] start_mem [MAX_BLOCKS];
  logic [23:0] size_mem  [MAX_BLOCKS];
  logic        free_mem  [MAX_BLOCKS];

  logic [1:0]    state_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic [24:0]   brk_r;
  ffha_pkg::req_t req_r;
  logic [23:0]   rd_start_r, rd_size_r;
  logic          rd_free_r;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [23:0]   wr_start, wr_size;
  logic          wr_free;
  logic [25:0]   need, pay_w;
  logic [25:0]   end_w;

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign need = {1'b0, brk_r} + 26'(HEADER_BYTES) + {2'b0, req_r.size};
  assign pay_w = {2'b0, rd_start_r} + 26'(HEADER_BYTES);
  assign end_w = pay_w + {2'b0, rd_size_r};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_idx] <= wr_start;
      size_mem[wr_idx] <= wr_size;
      free_mem[wr_idx] <= wr_free;
    end
    rd_start_r <= start_mem[idx_r[IW-1:0]];
    rd_size_r  <= size_mem[idx_r[IW-1:0]];
    rd_free_r  <= free_mem[idx_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      brk_r <= 25'd0;
      done <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      done <= 1'b0;
      wr_en <= 1'b0;
      if (base_wr && cnt_r == '0) brk_r <= {1'b0, heap_base};
      case (state_r)
        S_IDLE: if (q_valid) begin
          req_r <= q_req;
          idx_r <= '0;
          if (q_req.nul) begin
            // null request: answered straight from the queue head
            done <= 1'b1; st <= ffha_pkg::ST_NULL; pay <= 24'd0;
            reused <= 1'b0; top <= 1'b0;
          end else begin
            state_r <= (cnt_r == '0) ? S_END : S_RD;
          end
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          if (req_r.kind == ffha_pkg::REQ_ALLOC && rd_free_r
              && rd_size_r >= req_r.size) begin
            wr_en <= 1'b1; wr_idx <= idx_r[IW-1:0];
            wr_start <= rd_start_r; wr_size <= rd_size_r; wr_free <= 1'b0;
            done <= 1'b1; st <= ffha_pkg::ST_OK; pay <= pay_w[23:0];
            reused <= 1'b1; top <= 1'b0; state_r <= S_IDLE;
          end else if (req_r.kind == ffha_pkg::REQ_RELEASE
                       && pay_w == {2'b0, req_r.addr}) begin
            done <= 1'b1; st <= ffha_pkg::ST_OK; pay <= 24'd0; reused <= 1'b0;
            if (idx_r + 1'b1 == cnt_r && end_w == {1'b0, brk_r}) begin
              brk_r <= {1'b0, rd_start_r};
              cnt_r <= cnt_r - 1'b1;
              top <= 1'b1;
            end else begin
              wr_en <= 1'b1; wr_idx <= idx_r[IW-1:0];
              wr_start <= rd_start_r; wr_size <= rd_size_r; wr_free <= 1'b1;
              top <= 1'b0;
            end
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= (idx_r + 1'b1 == cnt_r) ? S_END : S_RD;
          end
        end
        S_END: begin
          done <= 1'b1; pay <= 24'd0; reused <= 1'b0; top <= 1'b0;
          state_r <= S_IDLE;
          if (req_r.kind == ffha_pkg::REQ_RELEASE) st <= ffha_pkg::ST_UNKNOWN;
          else if (cnt_r == CW'(MAX_BLOCKS)) st <= ffha_pkg::ST_TABLE_FULL;
          else if (need > {1'b0, heap_limit}) st <= ffha_pkg::ST_HEAP_FULL;
          else begin
            wr_en <= 1'b1; wr_idx <= cnt_r[IW-1:0];
            wr_start <= brk_r[23:0]; wr_size <= req_r.size; wr_free <= 1'b0;
            cnt_r <= cnt_r + 1'b1;
            brk_r <= need[24:0];
            st <= ffha_pkg::ST_OK;
            pay <= 24'({1'b0, brk_r} + 26'(HEADER_BYTES));
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> verif/ffha_checker.sv
`timescale 1ns / 1ps

module ffha_checker #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_req_type,
  input  logic [23:0] in_request_size,
  input  logic [23:0] in_block_address,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [24:0] cfg_wdata,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic [23:0] out_payload_address,
  input  logic        out_reused_block,
  input  logic        out_top_released,
  output int          err_count,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] payload;
    logic        reused;
    logic        top;
  } alloc_resp_t;

  // shadow of the block table
  logic [23:0] blk_start [MAX_BLOCKS];
  logic [23:0] blk_size  [MAX_BLOCKS];
  logic        blk_free  [MAX_BLOCKS];
  int          blk_count;
  logic [24:0] brk;
  logic [23:0] base_q;
  logic [24:0] limit_q;

  alloc_resp_t resp_q[$];

  function automatic alloc_resp_t serve_alloc(logic [23:0] size);
    alloc_resp_t r;
    logic [26:0] need;
    r = '0;
    if (size == 0) begin
      r.status = ffha_pkg::ST_NULL;
      return r;
    end
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= size) begin
        blk_free[i] = 1'b0;
        r.status  = ffha_pkg::ST_OK;
        r.payload = blk_start[i] + 24'(HEADER_BYTES);
        r.reused  = 1'b1;
        return r;
      end
    end
    if (blk_count >= MAX_BLOCKS) begin
      r.status = ffha_pkg::ST_TABLE_FULL;
      return r;
    end
    need = 27'(brk) + 27'(HEADER_BYTES) + 27'(size);
    if (need > 27'(limit_q)) begin
      r.status = ffha_pkg::ST_HEAP_FULL;
      return r;
    end
    blk_start[blk_count] = brk[23:0];
    blk_size[blk_count]  = size;
    blk_free[blk_count]  = 1'b0;
    blk_count++;
    r.status  = ffha_pkg::ST_OK;
    r.payload = brk[23:0] + 24'(HEADER_BYTES);
    brk = need[24:0];
    return r;
  endfunction

  function automatic alloc_resp_t serve_release(logic [23:0] addr);
    alloc_resp_t r;
    r = '0;
    if (addr == 0) begin
      r.status = ffha_pkg::ST_NULL;
      return r;
    end
    for (int i = 0; i < blk_count; i++) begin
      if (27'(blk_start[i]) + 27'(HEADER_BYTES) == 27'(addr)) begin
        r.status = ffha_pkg::ST_OK;
        if (i + 1 == blk_count &&
            27'(blk_start[i]) + 27'(HEADER_BYTES) + 27'(blk_size[i]) == 27'(brk)) begin
          brk = 25'(blk_start[i]);
          blk_count--;
          r.top = 1'b1;
        end else begin
          blk_free[i] = 1'b1;
        end
        return r;
      end
    end
    r.status = ffha_pkg::ST_UNKNOWN;
    return r;
  endfunction

  assign pending = resp_q.size();

  always @(posedge clk) begin
    alloc_resp_t want;
    alloc_resp_t got;
    if (!rst_n) begin
      blk_count = 0;
      base_q    = '0;
      limit_q   = 25'h1000000;
      brk       = '0;
      resp_q.delete();
      err_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ffha_pkg::CFG_BASE) begin
          base_q = cfg_wdata[23:0];
          if (blk_count == 0) brk = 25'(base_q);
        end else begin
          limit_q = cfg_wdata;
        end
      end
      // response check first: a response can never belong to this edge's request
      if (out_valid) begin
        got = '{out_status, out_payload_address, out_reused_block, out_top_released};
        if (resp_q.size() == 0) begin
          $display("%0t: unexpected response %h", $time, got);
          err_count++;
        end else begin
          want = resp_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            err_count++;
          end
          if (got.payload !== want.payload) begin
            $display("%0t: payload_address exp %h got %h", $time, want.payload, got.payload);
            err_count++;
          end
          if (got.reused !== want.reused) begin
            $display("%0t: reused_block exp %b got %b", $time, want.reused, got.reused);
            err_count++;
          end
          if (got.top !== want.top) begin
            $display("%0t: top_released exp %b got %b", $time, want.top, got.top);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        if (in_req_type == ffha_pkg::REQ_ALLOC) begin
          resp_q.push_back(serve_alloc(in_request_size));
        end else begin
          resp_q.push_back(serve_release(in_block_address));
        end
      end
    end
  end

endmodule

>>> verif/first_fit_heap_allocator_tb.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 150;   // worst-case scan latency plus margin

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_req_type = ffha_pkg::REQ_ALLOC;
  logic [23:0] in_request_size = '0;
  logic [23:0] in_block_address = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = ffha_pkg::CFG_BASE;
  logic [24:0] cfg_wdata = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [23:0] out_payload_address;
  logic        out_reused_block;
  logic        out_top_released;
  int          err_count;
  int          pending;
  int          cycles = 0;

  // payload addresses handed out so far; release traffic draws from here
  logic [23:0] live_addrs[$];

  always #1 clk = ~clk;

  first_fit_heap_allocator dut (.*);

  ffha_checker chk (.*);

  // harvest successful allocations so releases can hit real blocks
  always @(posedge clk) begin
    if (rst_n && out_valid && out_status == ffha_pkg::ST_OK && out_payload_address != 0) begin
      live_addrs.push_back(out_payload_address);
      if (live_addrs.size() > 128) void'(live_addrs.pop_front());
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("first_fit_heap_allocator_tb: errors");
      $finish;
    end
  end

  // one request transfer; start stays high across back-to-back transfers
  task automatic issue(logic kind, logic [23:0] size, logic [23:0] addr);
    int gap;
    bit taken;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_req_type      <= kind;
    in_request_size  <= size;
    in_block_address <= addr;
    // busy is checked mid-cycle so the accepting edge is known without a race
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic alloc_req(logic [23:0] size);
    issue(ffha_pkg::REQ_ALLOC, size, 24'($urandom()));
  endtask

  task automatic release_req(logic [23:0] addr);
    issue(ffha_pkg::REQ_RELEASE, 24'($urandom()), addr);
  endtask

  // drain, let any scan finish, then write a register
  task automatic write_reg(logic idx, logic [24:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_burst(int n, int size_cap);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // mostly modest sizes so the table fills; some wide ones to hit heap full
        if ($urandom_range(0, 9) == 0) alloc_req(24'($urandom()));
        else alloc_req(24'($urandom_range(1, size_cap)));
      end else if (pick < 90 && live_addrs.size() > 0) begin
        // newest blocks most often, so the break really shrinks
        if ($urandom_range(0, 1) == 0) release_req(live_addrs[live_addrs.size() - 1]);
        else release_req(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
      end else if (pick < 95) begin
        release_req(24'($urandom()));
      end else begin
        if ($urandom_range(0, 1) == 0) alloc_req('0);
        else release_req('0);
      end
    end
  endtask

  initial begin
    logic [23:0] a;
    logic [23:0] b;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(ffha_pkg::CFG_BASE, 25'h000100);
    write_reg(ffha_pkg::CFG_LIMIT, 25'h1000000);

    // directed: null cases, extremes, reuse, double release, no cascade
    alloc_req('0);
    release_req('0);
    release_req(24'hFFFFFF);
    alloc_req(24'hFFFFFF);
    alloc_req(24'd1);
    release_req(24'h000110);
    a = 24'h000110;
    alloc_req(24'd40);
    b = 24'h000110 + 24'd56;
    alloc_req(24'd8);
    release_req(a);
    release_req(a);
    alloc_req(24'd32);
    alloc_req(24'd41);
    release_req(a);
    release_req(b + 24'd24);
    release_req(b);
    release_req(a + 24'd1);
    alloc_req(24'hFFFEC0);
    alloc_req(24'd1);

    // wide open heap: table fills up, table-full path
    random_burst(400, 64);
    // base moves only when the table is empty
    write_reg(ffha_pkg::CFG_BASE, 25'hFFFFFF);
    write_reg(ffha_pkg::CFG_LIMIT, 25'h0004000);
    random_burst(300, 512);
    // limit at zero: every append overflows
    write_reg(ffha_pkg::CFG_LIMIT, 25'h0000000);
    random_burst(150, 64);
    // tight limit near the top of the space
    write_reg(ffha_pkg::CFG_BASE, 25'h000000);
    write_reg(ffha_pkg::CFG_LIMIT, 25'h1000000);
    random_burst(350, 4096);
    write_reg(ffha_pkg::CFG_LIMIT, 25'h0FFFFFF);
    random_burst(300, 128);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("first_fit_heap_allocator_tb: clean");
    end else begin
      $display("first_fit_heap_allocator_tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ffha_pkg.sv
rtl/ffha_front.sv
rtl/ffha_back.sv
rtl/first_fit_heap_allocator.sv
verif/ffha_checker.sv
verif/first_fit_heap_allocator_tb.sv
